### rtl/kbs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kbs_pkg: shared types, constants and functions
// Reset values, register codes, CORDIC constants and saturation helper for
// the kinematic bicycle step unit.
// ----------------------------------------------------------------------------
package kbs_pkg;

    localparam int ANGLE_BITS_DEF = 16;
    localparam int TRIG_ITER_DEF  = 16;

    localparam int MUL_W      = 32;
    localparam int DIV_DVD_W  = 56;
    localparam int DIV_DVS_W  = 32;
    localparam int IN_DATA_W  = 32;
    localparam int OUT_DATA_W = 120;

    localparam logic [15:0] TIME_STEP_RST = 16'd6554;
    localparam logic [15:0] WHEELBASE_RST = 16'd640;
    localparam logic [15:0] FRICTION_RST  = 16'd256;
    localparam logic [7:0]  TIMEOUT_RST   = 8'd10;

    localparam logic [7:0] CFG_TIME_STEP = 8'd0;
    localparam logic [7:0] CFG_WHEELBASE = 8'd1;
    localparam logic [7:0] CFG_FRICTION  = 8'd2;
    localparam logic [7:0] CFG_TIMEOUT   = 8'd3;

    localparam logic signed [33:0] CORDIC_GAIN  = 34'sd652032874;
    localparam logic signed [31:0] INV_TWO_PI   = 32'sd683565276;
    localparam logic signed [15:0] STEER_LIMIT  = 16'sd16000;
    localparam logic signed [33:0] QUARTER_TURN = 34'sd1073741824;
    localparam logic signed [33:0] HALF_TURN    = 34'sd2147483648;

    typedef logic signed [31:0] t_q16;

    // atan(2^-i) in units of 2^32 per turn
    function automatic logic signed [33:0] atan_turn(input logic [4:0] idx);
        logic signed [33:0] v;
        case (idx)
            5'd0:  v = 34'sh020000000;
            5'd1:  v = 34'sh012E4051E;
            5'd2:  v = 34'sh009FB385B;
            5'd3:  v = 34'sh0051111D4;
            5'd4:  v = 34'sh0028B0D43;
            5'd5:  v = 34'sh00145D7E1;
            5'd6:  v = 34'sh000A2F61E;
            5'd7:  v = 34'sh000517C55;
            5'd8:  v = 34'sh00028BE53;
            5'd9:  v = 34'sh000145F2F;
            5'd10: v = 34'sh0000A2F98;
            5'd11: v = 34'sh0000517CC;
            5'd12: v = 34'sh000028BE6;
            5'd13: v = 34'sh0000145F3;
            5'd14: v = 34'sh00000A2FA;
            5'd15: v = 34'sh00000517D;
            5'd16: v = 34'sh0000028BE;
            5'd17: v = 34'sh00000145F;
            5'd18: v = 34'sh000000A30;
            5'd19: v = 34'sh000000518;
            5'd20: v = 34'sh00000028C;
            5'd21: v = 34'sh000000146;
            5'd22: v = 34'sh0000000A3;
            5'd23: v = 34'sh000000051;
            default: v = 34'sd0;
        endcase
        return v;
    endfunction

    function automatic t_q16 sat32(input logic signed [34:0] v);
        t_q16 r;
        if (v > 35'sd2147483647) begin
            r = 32'sh7FFFFFFF;
        end else if (v < -35'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

### rtl/kinematic_bicycle_step_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kinematic_bicycle_step_unit: fixed-point kinematic bicycle pose integrator
// Command transactions latch acceleration and steering; tick transactions
// integrate speed, position and heading by one time step.
// ----------------------------------------------------------------------------
// Every input transaction produces exactly one output transaction carrying the
// pose after it. A command transaction (tuser = 0) is accepted in the idle
// state and then loads the output register. A tick transaction (tuser = 1)
// runs a sequencer over one shared bit-serial 32x32 multiplier (a start, one
// step per multiplier bit and a done for each product; seven products), one
// shared iterative CORDIC (run twice) and one restoring divider (run twice).
// One transaction is worked on at a time; the finished result sits in an
// output register, so the upstream side sees ready again once that register
// is loaded. A stalled output register holds the final step and adds its
// stall cycles.
// Configuration writes are always ready and must only be issued while the
// unit is idle.
// ----------------------------------------------------------------------------
module kinematic_bicycle_step_unit
    import kbs_pkg::*;
#(
    parameter int ANGLE_BITS      = ANGLE_BITS_DEF,
    parameter int TRIG_ITERATIONS = TRIG_ITER_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // input stream
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    input  logic [IN_DATA_W-1:0]  i_s_axis_tdata,  // acc_command[15:0], steer_command[30:16]
    input  logic                  i_s_axis_tuser,  // mode[0]
    // output stream
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    // pos_x[31:0], pos_y[63:32], heading[79:64], speed[111:80], commands_stale[112]
    output logic [OUT_DATA_W-1:0] o_m_axis_tdata,
    // configuration write channel
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [7:0]            i_cfg_index,
    input  logic [15:0]           i_cfg_data
);
    localparam int ITER_W = $clog2(TRIG_ITERATIONS + 1);

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_ACC  = 4'd1;
    localparam logic [3:0] ST_FRIC = 4'd2;
    localparam logic [3:0] ST_DIST = 4'd3;
    localparam logic [3:0] ST_COR1 = 4'd4;
    localparam logic [3:0] ST_MULX = 4'd5;
    localparam logic [3:0] ST_MULY = 4'd6;
    localparam logic [3:0] ST_COR2 = 4'd7;
    localparam logic [3:0] ST_DIV1 = 4'd8;
    localparam logic [3:0] ST_MULT = 4'd9;
    localparam logic [3:0] ST_DIV2 = 4'd10;
    localparam logic [3:0] ST_MULK = 4'd11;
    localparam logic [3:0] ST_DONE = 4'd12;

    // configuration
    logic [15:0] r_time_step, r_wheelbase, r_friction;
    logic [7:0]  r_timeout;

    // architectural state
    t_q16                  r_x, n_x, r_y, n_y, r_v, n_v;
    logic [ANGLE_BITS-1:0] r_yaw, n_yaw;
    logic [15:0]           r_hacc, n_hacc;
    logic [14:0]           r_hst, n_hst;
    logic [7:0]            r_tsc, n_tsc;

    // sequencer and working registers
    logic [3:0]         r_state, n_state;
    logic               r_go, n_go;
    t_q16               r_d, n_d, r_c, n_c, r_s, n_s, r_t, n_t, r_rad, n_rad;
    logic               r_neg, n_neg;
    logic [DIV_DVD_W-1:0] r_dvd, n_dvd;
    logic signed [33:0] r_cx, n_cx, r_cy, n_cy, r_cz, n_cz;
    logic [ITER_W-1:0]  r_ci, n_ci;
    logic               r_flip, n_flip;

    // output register
    logic                  r_ov, n_ov;
    logic [OUT_DATA_W-1:0] r_odata, n_odata;

    // shared arithmetic units
    logic                   mul_start, mul_done;
    logic signed [MUL_W-1:0]   mul_a, mul_b;
    logic signed [2*MUL_W-1:0] mul_p;
    logic                   div_start, div_done;
    logic [DIV_DVD_W-1:0]   div_dvd, div_q;
    logic [DIV_DVS_W-1:0]   div_dvs;

    kbs_serial_mul #(.W(MUL_W)) u_mul (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (mul_start),
        .i_a       (mul_a),
        .i_b       (mul_b),
        .o_done    (mul_done),
        .o_product (mul_p)
    );

    kbs_serial_div #(.DVD_W(DIV_DVD_W), .DVS_W(DIV_DVS_W)) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dvd),
        .i_divisor  (div_dvs),
        .o_done     (div_done),
        .o_quotient (div_q)
    );

    // input unpacking
    logic        w_mode;
    logic [15:0] w_acc_cmd;
    logic [14:0] w_steer_cmd;
    logic        w_in_xfer;
    assign w_mode      = i_s_axis_tuser;
    assign w_acc_cmd   = i_s_axis_tdata[15:0];
    assign w_steer_cmd = i_s_axis_tdata[30:16];
    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign w_in_xfer   = i_s_axis_tvalid && o_s_axis_tready;

    assign o_cfg_ready     = 1'b1;
    assign o_m_axis_tvalid = r_ov;
    assign o_m_axis_tdata  = r_odata;

    // heading: top 16 bits of the yaw angle
    logic [15:0] w_heading;
    generate
        if (ANGLE_BITS >= 16) begin : g_head_shr
            assign w_heading = r_yaw[ANGLE_BITS-1 -: 16];
        end else begin : g_head_shl
            assign w_heading = {r_yaw, {(16-ANGLE_BITS){1'b0}}};
        end
    endgenerate

    // clamped steering, as a signed 16-bit binary angle
    logic signed [15:0] w_st_ext, w_st_clamp;
    always_comb begin
        w_st_ext = 16'(signed'(r_hst));
        if (w_st_ext > STEER_LIMIT) begin
            w_st_clamp = STEER_LIMIT;
        end else if (w_st_ext < -STEER_LIMIT) begin
            w_st_clamp = -STEER_LIMIT;
        end else begin
            w_st_clamp = w_st_ext;
        end
    end

    // CORDIC: start angle for the current pass and one rotation step
    logic [31:0]        w_ang;
    logic signed [33:0] w_za, w_z0;
    logic               w_flip0;
    logic signed [33:0] w_sx, w_sy, w_at;
    logic signed [33:0] w_nx, w_ny, w_nz;
    logic signed [33:0] w_cres, w_sres;
    always_comb begin
        if (r_state == ST_COR1) begin
            w_ang = {r_yaw, {(32-ANGLE_BITS){1'b0}}};
        end else begin
            w_ang = {w_st_clamp, 16'h0000};
        end
        w_za = 34'(signed'(w_ang));
        if (w_za > QUARTER_TURN) begin
            w_z0    = w_za - HALF_TURN;
            w_flip0 = 1'b1;
        end else if (w_za < -QUARTER_TURN) begin
            w_z0    = w_za + HALF_TURN;
            w_flip0 = 1'b1;
        end else begin
            w_z0    = w_za;
            w_flip0 = 1'b0;
        end
        w_sx = r_cx >>> r_ci;
        w_sy = r_cy >>> r_ci;
        w_at = atan_turn(5'(r_ci));
        if (r_cz >= 0) begin
            w_nx = r_cx - w_sy;
            w_ny = r_cy + w_sx;
            w_nz = r_cz - w_at;
        end else begin
            w_nx = r_cx + w_sy;
            w_ny = r_cy - w_sx;
            w_nz = r_cz + w_at;
        end
        w_cres = r_flip ? -r_cx : r_cx;
        w_sres = r_flip ? -r_cy : r_cy;
    end

    // datapath helpers fed from the multiplier and divider results
    logic signed [32:0]   w_dv;
    logic [23:0]          w_fric;
    logic signed [32:0]   w_fric_dn, w_fric_up;
    logic signed [33:0]   w_pos_inc;
    logic [7:0]           w_tsc_inc;
    logic [31:0]          w_abs_s, w_q32;
    logic signed [63:0]   w_abs_p;
    logic [15:0]          w_len;
    logic [30:0]          w_qc;
    t_q16                 w_sc_fix;
    always_comb begin
        w_dv      = mul_p[40:8];
        w_fric    = mul_p[31:8];
        w_fric_dn = 33'(r_v) - $signed({9'b0, w_fric});
        w_fric_up = 33'(r_v) + $signed({9'b0, w_fric});
        w_pos_inc = mul_p[63:30];
        w_tsc_inc = (r_tsc == 8'hFF) ? r_tsc : r_tsc + 8'd1;
        w_abs_s   = r_s[31] ? 32'(-r_s) : 32'(r_s);
        w_q32     = div_q[31:0];
        w_abs_p   = mul_p[63] ? -mul_p : mul_p;
        w_len     = (r_wheelbase == 16'd0) ? 16'd1 : r_wheelbase;
        w_qc      = (|div_q[DIV_DVD_W-1:31]) ? 31'h7FFFFFFF : div_q[30:0];
        w_sc_fix  = ($signed(w_cres[31:0]) <= 32'sd0) ? 32'sd1 : w_cres[31:0];
    end

    // sequencer
    always_comb begin
        n_state = r_state;
        n_go    = r_go;
        n_x     = r_x;
        n_y     = r_y;
        n_v     = r_v;
        n_yaw   = r_yaw;
        n_hacc  = r_hacc;
        n_hst   = r_hst;
        n_tsc   = r_tsc;
        n_d     = r_d;
        n_c     = r_c;
        n_s     = r_s;
        n_t     = r_t;
        n_rad   = r_rad;
        n_neg   = r_neg;
        n_dvd   = r_dvd;
        n_cx    = r_cx;
        n_cy    = r_cy;
        n_cz    = r_cz;
        n_ci    = r_ci;
        n_flip  = r_flip;
        n_ov    = r_ov && !i_m_axis_tready;
        n_odata = r_odata;

        mul_start = 1'b0;
        mul_a     = '0;
        mul_b     = '0;
        div_start = 1'b0;
        div_dvd   = '0;
        div_dvs   = '0;

        // operand select for the shared units
        case (r_state)
            ST_ACC: begin
                mul_a = 32'(signed'(r_hacc));
                mul_b = 32'({16'h0000, r_time_step});
            end
            ST_FRIC: begin
                mul_a = 32'({16'h0000, r_friction});
                mul_b = 32'({16'h0000, r_time_step});
            end
            ST_DIST: begin
                mul_a = r_v;
                mul_b = 32'({16'h0000, r_time_step});
            end
            ST_MULX: begin
                mul_a = r_d;
                mul_b = r_c;
            end
            ST_MULY: begin
                mul_a = r_d;
                mul_b = r_s;
            end
            ST_MULT: begin
                mul_a = r_d;
                mul_b = r_t;
            end
            ST_MULK: begin
                mul_a = r_rad;
                mul_b = INV_TWO_PI;
            end
            ST_DIV1: begin
                div_dvd = DIV_DVD_W'({w_abs_s, 16'h0000});
                div_dvs = r_c;
            end
            ST_DIV2: begin
                div_dvd = r_dvd;
                div_dvs = DIV_DVS_W'(w_len);
            end
            default: begin
            end
        endcase

        case (r_state)
            ST_IDLE: begin
                if (w_in_xfer) begin
                    if (!w_mode) begin
                        // drive command: latch and restart the staleness count
                        n_hacc  = w_acc_cmd;
                        n_hst   = w_steer_cmd;
                        n_tsc   = 8'd0;
                        n_state = ST_DONE;
                    end else begin
                        n_tsc = w_tsc_inc;
                        if (w_tsc_inc > r_timeout) begin
                            n_hacc = 16'h0000;
                            n_hst  = 15'h0000;
                        end
                        n_state = ST_ACC;
                    end
                end
            end
            ST_ACC: begin
                if (!r_go) begin
                    mul_start = 1'b1;
                    n_go      = 1'b1;
                end else if (mul_done) begin
                    n_v     = sat32(35'(r_v) + 35'(w_dv));
                    n_go    = 1'b0;
                    n_state = ST_FRIC;
                end
            end
            ST_FRIC: begin
                if (!r_go) begin
                    mul_start = 1'b1;
                    n_go      = 1'b1;
                end else if (mul_done) begin
                    // coasting: pull toward zero without crossing it
                    if (r_hacc == 16'h0000) begin
                        if (r_v > 0) begin
                            n_v = (w_fric_dn < 0) ? 32'sd0 : w_fric_dn[31:0];
                        end else if (r_v < 0) begin
                            n_v = (w_fric_up > 0) ? 32'sd0 : w_fric_up[31:0];
                        end
                    end
                    n_go    = 1'b0;
                    n_state = ST_DIST;
                end
            end
            ST_DIST: begin
                if (!r_go) begin
                    mul_start = 1'b1;
                    n_go      = 1'b1;
                end else if (mul_done) begin
                    n_d     = mul_p[47:16];
                    n_go    = 1'b0;
                    n_state = ST_COR1;
                end
            end
            ST_COR1, ST_COR2: begin
                if (!r_go) begin
                    n_cx   = CORDIC_GAIN;
                    n_cy   = '0;
                    n_cz   = w_z0;
                    n_flip = w_flip0;
                    n_ci   = '0;
                    n_go   = 1'b1;
                end else if (r_ci != ITER_W'(TRIG_ITERATIONS)) begin
                    n_cx = w_nx;
                    n_cy = w_ny;
                    n_cz = w_nz;
                    n_ci = r_ci + 1'b1;
                end else begin
                    n_s  = w_sres[31:0];
                    n_go = 1'b0;
                    if (r_state == ST_COR1) begin
                        n_c     = w_cres[31:0];
                        n_state = ST_MULX;
                    end else begin
                        n_c     = w_sc_fix;
                        n_state = ST_DIV1;
                    end
                end
            end
            ST_MULX: begin
                if (!r_go) begin
                    mul_start = 1'b1;
                    n_go      = 1'b1;
                end else if (mul_done) begin
                    n_x     = sat32(35'(r_x) + 35'(w_pos_inc));
                    n_go    = 1'b0;
                    n_state = ST_MULY;
                end
            end
            ST_MULY: begin
                if (!r_go) begin
                    mul_start = 1'b1;
                    n_go      = 1'b1;
                end else if (mul_done) begin
                    n_y     = sat32(35'(r_y) + 35'(w_pos_inc));
                    n_go    = 1'b0;
                    n_state = ST_COR2;
                end
            end
            ST_DIV1: begin
                // tangent in Q16, truncated toward zero
                if (!r_go) begin
                    div_start = 1'b1;
                    n_neg     = r_s[31];
                    n_go      = 1'b1;
                end else if (div_done) begin
                    n_t     = r_neg ? -w_q32 : w_q32;
                    n_go    = 1'b0;
                    n_state = ST_MULT;
                end
            end
            ST_MULT: begin
                if (!r_go) begin
                    mul_start = 1'b1;
                    n_go      = 1'b1;
                end else if (mul_done) begin
                    n_neg   = mul_p[63];
                    n_dvd   = w_abs_p[DIV_DVD_W-1:0];
                    n_go    = 1'b0;
                    n_state = ST_DIV2;
                end
            end
            ST_DIV2: begin
                // turn rate in radians Q24, clamped to the 32-bit range
                if (!r_go) begin
                    div_start = 1'b1;
                    n_go      = 1'b1;
                end else if (div_done) begin
                    n_rad   = r_neg ? -{1'b0, w_qc} : {1'b0, w_qc};
                    n_go    = 1'b0;
                    n_state = ST_MULK;
                end
            end
            ST_MULK: begin
                if (!r_go) begin
                    mul_start = 1'b1;
                    n_go      = 1'b1;
                end else if (mul_done) begin
                    // wrap: only the low angle bits of the scaled turn matter
                    n_yaw   = r_yaw + mul_p[55 -: ANGLE_BITS];
                    n_go    = 1'b0;
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                // hold until the output register is free
                if (!r_ov || i_m_axis_tready) begin
                    n_ov    = 1'b1;
                    n_odata = {7'b0, (r_tsc > r_timeout), r_v, w_heading, r_y, r_x};
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
                n_go    = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_go        <= 1'b0;
            r_ov        <= 1'b0;
            r_x         <= '0;
            r_y         <= '0;
            r_v         <= '0;
            r_yaw       <= '0;
            r_hacc      <= '0;
            r_hst       <= '0;
            r_tsc       <= '0;
            r_time_step <= TIME_STEP_RST;
            r_wheelbase <= WHEELBASE_RST;
            r_friction  <= FRICTION_RST;
            r_timeout   <= TIMEOUT_RST;
        end else begin
            r_state <= n_state;
            r_go    <= n_go;
            r_ov    <= n_ov;
            r_x     <= n_x;
            r_y     <= n_y;
            r_v     <= n_v;
            r_yaw   <= n_yaw;
            r_hacc  <= n_hacc;
            r_hst   <= n_hst;
            r_tsc   <= n_tsc;
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_TIME_STEP: r_time_step <= i_cfg_data;
                    CFG_WHEELBASE: r_wheelbase <= i_cfg_data;
                    CFG_FRICTION:  r_friction  <= i_cfg_data;
                    CFG_TIMEOUT:   r_timeout   <= i_cfg_data[7:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    // working registers, no reset needed
    always_ff @(posedge i_clk) begin
        r_d     <= n_d;
        r_c     <= n_c;
        r_s     <= n_s;
        r_t     <= n_t;
        r_rad   <= n_rad;
        r_neg   <= n_neg;
        r_dvd   <= n_dvd;
        r_cx    <= n_cx;
        r_cy    <= n_cy;
        r_cz    <= n_cz;
        r_ci    <= n_ci;
        r_flip  <= n_flip;
        r_odata <= n_odata;
    end

endmodule

### rtl/kbs_serial_mul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kbs_serial_mul: bit-serial signed multiplier
// Consumes one multiplier bit per cycle, LSB first; the sign bit carries
// negative weight. Result valid on the done pulse.
// ----------------------------------------------------------------------------
module kbs_serial_mul
    import kbs_pkg::*;
#(
    parameter int W = MUL_W
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic signed [W-1:0]   i_a,
    input  logic signed [W-1:0]   i_b,
    output logic                  o_done,
    output logic signed [2*W-1:0] o_product
);
    localparam int CNT_W = $clog2(W);

    logic signed [W-1:0] r_a;
    logic signed [W:0]   r_hi;
    logic [W-1:0]        r_lo;
    logic [CNT_W-1:0]    r_cnt;
    logic                r_busy, r_done;

    logic                w_last;
    logic signed [W+1:0] w_addend, w_sum;

    assign w_last = (r_cnt == CNT_W'(W - 1));

    always_comb begin
        if (!r_lo[0]) begin
            w_addend = '0;
        end else if (w_last) begin
            w_addend = -((W+2)'(r_a));
        end else begin
            w_addend = (W+2)'(r_a);
        end
        w_sum = (W+2)'(r_hi) + w_addend;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && w_last;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (w_last) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a  <= i_a;
            r_hi <= '0;
            r_lo <= i_b;
        end else if (r_busy) begin
            r_hi <= w_sum[W+1:1];
            r_lo <= {w_sum[0], r_lo[W-1:1]};
        end
    end

    assign o_done    = r_done;
    assign o_product = {r_hi[W-1:0], r_lo};

endmodule

### rtl/kbs_serial_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kbs_serial_div: restoring unsigned divider
// One quotient bit per cycle, MSB first. Quotient valid on the done pulse.
// ----------------------------------------------------------------------------
module kbs_serial_div
    import kbs_pkg::*;
#(
    parameter int DVD_W = DIV_DVD_W,
    parameter int DVS_W = DIV_DVS_W
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DVD_W-1:0] i_dividend,
    input  logic [DVS_W-1:0] i_divisor,
    output logic             o_done,
    output logic [DVD_W-1:0] o_quotient
);
    localparam int CNT_W = $clog2(DVD_W);

    logic [DVS_W:0]   r_rem;
    logic [DVD_W-1:0] r_q;
    logic [DVS_W-1:0] r_dvs;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy, r_done;

    logic             w_last;
    logic [DVS_W:0]   w_rem_sh;
    logic [DVS_W+1:0] w_diff;

    assign w_last   = (r_cnt == CNT_W'(DVD_W - 1));
    assign w_rem_sh = {r_rem[DVS_W-1:0], r_q[DVD_W-1]};
    assign w_diff   = {1'b0, w_rem_sh} - {2'b00, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && w_last;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (w_last) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_q   <= i_dividend;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            if (!w_diff[DVS_W+1]) begin
                r_rem <= w_diff[DVS_W:0];
                r_q   <= {r_q[DVD_W-2:0], 1'b1};
            end else begin
                r_rem <= w_rem_sh;
                r_q   <= {r_q[DVD_W-2:0], 1'b0};
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_q;

endmodule
